@@ rtl/core/wfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Warped frame difference package
// Shared widths, register indexes, reset values and payload types.
// ----------------------------------------------------------------------------
package wfd_pkg;

  localparam int NUM_TERMS = 6;
  localparam int COEF_W    = 32;
  localparam int FRAC_W    = 20;
  localparam int TERM_W    = 18;                 // col*col of a 9-bit column
  localparam int PROD_W    = COEF_W + TERM_W + 1;
  localparam int PSUM_W    = PROD_W + 1;
  localparam int ACC_W     = PROD_W + 3;
  localparam int Q_W       = ACC_W - FRAC_W;
  localparam int REG_IDX_W = 3;
  localparam int PAIR_W    = 2 * COEF_W;

  localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_0     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_1     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_2     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_3     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_4     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_COEF_5     = 3'd6;

  localparam logic [2:0]        TERM_COUNT_RST = 3'd3;
  localparam logic [PAIR_W-1:0] COEF_0_RST     = 64'h0000_0000_0010_0000;
  localparam logic [PAIR_W-1:0] COEF_1_RST     = 64'h0010_0000_0000_0000;

  typedef struct packed {
    logic [7:0] pixel_row;
    logic [8:0] pixel_col;
    logic [7:0] pix_b;
    logic [7:0] pix_g;
    logic [7:0] pix_r;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic [2:0]                          term_count;
    logic [NUM_TERMS-1:0][COEF_W-1:0]    coef_x;
    logic [NUM_TERMS-1:0][COEF_W-1:0]    coef_y;
  } warp_cfg_t;

endpackage

@@ rtl/core/wfd_pix_if.sv @@
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one raster pixel per word.
// ----------------------------------------------------------------------------
interface wfd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_row;
  logic [8:0] pixel_col;
  logic [7:0] pix_b;
  logic [7:0] pix_g;
  logic [7:0] pix_r;
  logic       frame_end;

  modport source (output valid, pixel_row, pixel_col, pix_b, pix_g, pix_r, frame_end,
                  input ready);
  modport sink   (input valid, pixel_row, pixel_col, pix_b, pix_g, pix_r, frame_end,
                  output ready);
endinterface

@@ rtl/core/wfd_res_if.sv @@
// ----------------------------------------------------------------------------
// Difference result channel
// Valid/ready channel carrying one difference result per word.
// ----------------------------------------------------------------------------
interface wfd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] delta_max;
  logic [7:0] delta_b;
  logic [7:0] delta_g;
  logic [7:0] delta_r;
  logic       at_border;
  logic       frame_last;

  modport source (output valid, delta_max, delta_b, delta_g, delta_r, at_border, frame_last,
                  input ready);
  modport sink   (input valid, delta_max, delta_b, delta_g, delta_r, at_border, frame_last,
                  output ready);
endinterface

@@ rtl/core/wfd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/wfd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module wfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 57600
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/wfd_warp.sv @@
// ----------------------------------------------------------------------------
// Polynomial warp pipeline
// Five stages: terms, products, pair sums, final sum, truncate and clamp.
// ----------------------------------------------------------------------------
module wfd_warp #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 180
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  wfd_pkg::pix_t                   in_pix,
  input  wfd_pkg::warp_cfg_t              cfg,
  output logic                            out_valid,
  output wfd_pkg::pix_t                   out_pix,
  output logic [$clog2(FRAME_WIDTH)-1:0]  wx,
  output logic [$clog2(FRAME_HEIGHT)-1:0] wy
);
  import wfd_pkg::*;

  localparam int XW     = $clog2(FRAME_WIDTH);
  localparam int YW     = $clog2(FRAME_HEIGHT);
  localparam int STAGES = 5;

  logic [STAGES-1:0]       v_r;
  pix_t                    pix_r [STAGES];

  logic [TERM_W-1:0]       tx_nxt [NUM_TERMS];
  logic [TERM_W-1:0]       ty_nxt [NUM_TERMS];
  logic [TERM_W-1:0]       tx_r   [NUM_TERMS];
  logic [TERM_W-1:0]       ty_r   [NUM_TERMS];
  logic signed [PROD_W-1:0] px_r  [NUM_TERMS];
  logic signed [PROD_W-1:0] py_r  [NUM_TERMS];
  logic signed [PSUM_W-1:0] sx_r  [NUM_TERMS/2];
  logic signed [PSUM_W-1:0] sy_r  [NUM_TERMS/2];
  logic signed [ACC_W-1:0]  accx_r;
  logic signed [ACC_W-1:0]  accy_r;
  logic [XW-1:0]           wx_nxt, wx_r;
  logic [YW-1:0]           wy_nxt, wy_r;

  logic [TERM_W-1:0]       col_t, row_t, cc, rr, cr;
  logic signed [ACC_W-1:0] biasx, biasy;
  logic signed [Q_W-1:0]   qx, qy;

  // Stage 1: build the term vectors for the selected polynomial order.
  always_comb begin
    col_t = TERM_W'(in_pix.pixel_col);
    row_t = TERM_W'(in_pix.pixel_row);
    cc    = col_t * col_t;
    rr    = row_t * row_t;
    cr    = col_t * row_t;
    for (int k = 0; k < NUM_TERMS; k++) begin
      tx_nxt[k] = '0;
      ty_nxt[k] = '0;
    end
    tx_nxt[0] = col_t;
    ty_nxt[0] = col_t;
    tx_nxt[1] = row_t;
    ty_nxt[1] = row_t;
    tx_nxt[2] = TERM_W'(1);
    ty_nxt[2] = TERM_W'(1);
    case (cfg.term_count) inside
      [3'd0:3'd3]: begin
      end
      3'd4: begin
        tx_nxt[3] = cr;
        ty_nxt[3] = cr;
      end
      3'd5: begin
        tx_nxt[3] = cc;
        tx_nxt[4] = cr;
        ty_nxt[3] = rr;
        ty_nxt[4] = cr;
      end
      default: begin
        tx_nxt[3] = cc;
        tx_nxt[4] = rr;
        tx_nxt[5] = cr;
        ty_nxt[3] = cc;
        ty_nxt[4] = rr;
        ty_nxt[5] = cr;
      end
    endcase
  end

  // Stage 5: divide by 2^20 toward zero, then clamp into the frame.
  always_comb begin
    biasx = $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{accx_r[ACC_W-1]}}});
    biasy = $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{accy_r[ACC_W-1]}}});
    qx    = Q_W'((accx_r + biasx) >>> FRAC_W);
    qy    = Q_W'((accy_r + biasy) >>> FRAC_W);
    if (qx > $signed(Q_W'(FRAME_WIDTH - 1))) begin
      wx_nxt = XW'(FRAME_WIDTH - 1);
    end else if (qx[Q_W-1]) begin
      wx_nxt = '0;
    end else begin
      wx_nxt = qx[XW-1:0];
    end
    if (qy > $signed(Q_W'(FRAME_HEIGHT - 1))) begin
      wy_nxt = YW'(FRAME_HEIGHT - 1);
    end else if (qy[Q_W-1]) begin
      wy_nxt = '0;
    end else begin
      wy_nxt = qy[YW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r[0] <= in_pix;
      for (int s = 1; s < STAGES; s++) begin
        pix_r[s] <= pix_r[s-1];
      end
      for (int k = 0; k < NUM_TERMS; k++) begin
        tx_r[k] <= tx_nxt[k];
        ty_r[k] <= ty_nxt[k];
        px_r[k] <= $signed(cfg.coef_x[k]) * $signed({1'b0, tx_r[k]});
        py_r[k] <= $signed(cfg.coef_y[k]) * $signed({1'b0, ty_r[k]});
      end
      for (int j = 0; j < NUM_TERMS/2; j++) begin
        sx_r[j] <= PSUM_W'(px_r[2*j]) + PSUM_W'(px_r[2*j+1]);
        sy_r[j] <= PSUM_W'(py_r[2*j]) + PSUM_W'(py_r[2*j+1]);
      end
      accx_r <= ACC_W'(sx_r[0]) + ACC_W'(sx_r[1]) + ACC_W'(sx_r[2]);
      accy_r <= ACC_W'(sy_r[0]) + ACC_W'(sy_r[1]) + ACC_W'(sy_r[2]);
      wx_r   <= wx_nxt;
      wy_r   <= wy_nxt;
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_pix   = pix_r[STAGES-1];
  assign wx        = wx_r;
  assign wy        = wy_r;

endmodule

@@ rtl/core/warped_frame_difference_core.sv @@
// ----------------------------------------------------------------------------
// Warped frame difference core
// Per-pixel absolute difference against the warped previous frame.
//
// in_pix carries raster pixels of the current frame, one word per pixel,
// with frame_end on the last pixel of each frame. out_res returns one word
// per pixel, in order: the three channel differences, their maximum, the
// border flag and a copy of frame_end. cfg_wr writes the term count and the
// six x/y coefficient pairs; it is always ready and is meant to be written
// while no pixel is in flight.
// An accepted pixel passes the warp stages, stages 6 and 7 and the output
// register on its way to out_res. The pipeline takes one pixel every cycle
// unless out_res holds off or the clear runs; its pace is set by the frame
// store, two banks with one write and one read port each, both used once per
// pixel in the same stage. After reset the frame store is zeroed, both banks
// cleared in parallel; in_pix.ready stays low until that is done. When the
// receiver holds off, the whole pipeline holds and nothing is lost.
// ----------------------------------------------------------------------------
module warped_frame_difference_core #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 180
) (
  input  logic       clk,
  input  logic       rst_n,
  wfd_pix_if.sink    in_pix,
  wfd_res_if.source  out_res,
  wfd_cfg_if.sink    cfg_wr
);
  import wfd_pkg::*;

  localparam int XW    = $clog2(FRAME_WIDTH);
  localparam int YW    = $clog2(FRAME_HEIGHT);
  localparam int PLANE = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(PLANE);
  localparam int PIX_W = 24;

  // Configuration registers.
  logic [2:0]        term_count_r;
  logic [PAIR_W-1:0] coef_r [NUM_TERMS];
  warp_cfg_t         warp_cfg;

  // Control.
  logic          adv;
  logic          in_fire;
  logic          fire6;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          bank_sel_r, bank_sel_nxt;

  // Warp outputs.
  logic          wv;
  pix_t          wpix;
  logic [XW-1:0] wx;
  logic [YW-1:0] wy;
  pix_t          in_word;

  // Stage 6: addresses.
  logic          v6_r;
  pix_t          pix6_r;
  logic          border6_r;
  logic [AW-1:0] raddr6_r;
  logic [AW-1:0] waddr6_r;
  logic          wr_ok6_r;
  logic          border_nxt, wr_ok_nxt;
  logic [AW-1:0] raddr_nxt, waddr_nxt;

  // Stage 7: read data.
  logic          v7_r;
  pix_t          pix7_r;
  logic          border7_r;
  logic          rbank7_r;

  // Frame store ports.
  logic             we0, we1;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0] rdata0, rdata1, prev;

  // Output register.
  logic       out_valid_r;
  logic [7:0] db_nxt, dg_nxt, dr_nxt, dm_nxt;
  logic [7:0] delta_max_r, delta_b_r, delta_g_r, delta_r_r;
  logic       at_border_r, frame_last_r;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // ---------------- configuration ----------------
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_COUNT_RST;
      coef_r[0]    <= COEF_0_RST;
      coef_r[1]    <= COEF_1_RST;
      for (int k = 2; k < NUM_TERMS; k++) begin
        coef_r[k] <= '0;
      end
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_TERM_COUNT: begin
          term_count_r <= cfg_wr.data[2:0];
        end
        REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5: begin
          coef_r[REG_IDX_W'(cfg_wr.index - REG_COEF_0)] <= cfg_wr.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    warp_cfg.term_count = term_count_r;
    for (int k = 0; k < NUM_TERMS; k++) begin
      warp_cfg.coef_x[k] = coef_r[k][COEF_W-1:0];
      warp_cfg.coef_y[k] = coef_r[k][PAIR_W-1:COEF_W];
    end
  end

  // ---------------- pipeline control ----------------
  // Every stage moves together whenever the output register can take a word.
  assign adv          = !out_valid_r || out_res.ready;
  assign in_pix.ready = adv && !clr_busy_r;
  assign in_fire      = in_pix.valid && in_pix.ready;
  assign fire6        = adv && v6_r;

  assign in_word.pixel_row = in_pix.pixel_row;
  assign in_word.pixel_col = in_pix.pixel_col;
  assign in_word.pix_b     = in_pix.pix_b;
  assign in_word.pix_g     = in_pix.pix_g;
  assign in_word.pix_r     = in_pix.pix_r;
  assign in_word.frame_end = in_pix.frame_end;

  wfd_warp #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_warp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_fire),
    .in_pix    (in_word),
    .cfg       (warp_cfg),
    .out_valid (wv),
    .out_pix   (wpix),
    .wx        (wx),
    .wy        (wy)
  );

  // ---------------- stage 6: border and addresses ----------------
  always_comb begin
    border_nxt = (wx == '0) || (wx == XW'(FRAME_WIDTH - 1)) ||
                 (wy == '0) || (wy == YW'(FRAME_HEIGHT - 1));
    raddr_nxt  = AW'(32'(wy) * 32'(FRAME_WIDTH) + 32'(wx));
    waddr_nxt  = AW'(32'(wpix.pixel_row) * 32'(FRAME_WIDTH) + 32'(wpix.pixel_col));
    wr_ok_nxt  = (32'(wpix.pixel_row) < 32'(FRAME_HEIGHT)) &&
                 (32'(wpix.pixel_col) < 32'(FRAME_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v6_r <= wv;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix6_r    <= wpix;
      border6_r <= border_nxt;
      raddr6_r  <= raddr_nxt;
      waddr6_r  <= waddr_nxt;
      wr_ok6_r  <= wr_ok_nxt;
      pix7_r    <= pix6_r;
      border7_r <= border6_r;
      rbank7_r  <= ~bank_sel_r;
    end
  end

  // ---------------- frame store ----------------
  // The read of the previous frame and the write of the current pixel happen
  // for the same word at the same edge, so bank swaps stay in stream order.
  always_comb begin
    bank_sel_nxt = bank_sel_r;
    if (fire6 && pix6_r.frame_end) begin
      bank_sel_nxt = ~bank_sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_sel_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      bank_sel_r <= bank_sel_nxt;
      if (clr_busy_r) begin
        if (clr_addr_r == AW'(PLANE - 1)) begin
          clr_busy_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  assign we0       = clr_busy_r || (fire6 && wr_ok6_r && !bank_sel_r);
  assign we1       = clr_busy_r || (fire6 && wr_ok6_r && bank_sel_r);
  assign ram_waddr = clr_busy_r ? clr_addr_r : waddr6_r;
  assign ram_wdata = clr_busy_r ? '0 : {pix6_r.pix_r, pix6_r.pix_g, pix6_r.pix_b};

  wfd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PLANE)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (fire6),
    .raddr (raddr6_r),
    .rdata (rdata0)
  );

  wfd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PLANE)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (fire6),
    .raddr (raddr6_r),
    .rdata (rdata1)
  );

  // ---------------- stage 8: differences into the output register ----------------
  always_comb begin
    prev   = rbank7_r ? rdata1 : rdata0;
    db_nxt = absdiff(pix7_r.pix_b, prev[7:0]);
    dg_nxt = absdiff(pix7_r.pix_g, prev[15:8]);
    dr_nxt = absdiff(pix7_r.pix_r, prev[23:16]);
    dm_nxt = db_nxt;
    if (dg_nxt > dm_nxt) begin
      dm_nxt = dg_nxt;
    end
    if (dr_nxt > dm_nxt) begin
      dm_nxt = dr_nxt;
    end
    if (border7_r) begin
      db_nxt = '0;
      dg_nxt = '0;
      dr_nxt = '0;
      dm_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      delta_max_r  <= dm_nxt;
      delta_b_r    <= db_nxt;
      delta_g_r    <= dg_nxt;
      delta_r_r    <= dr_nxt;
      at_border_r  <= border7_r;
      frame_last_r <= pix7_r.frame_end;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.delta_max  = delta_max_r;
  assign out_res.delta_b    = delta_b_r;
  assign out_res.delta_g    = delta_g_r;
  assign out_res.delta_r    = delta_r_r;
  assign out_res.at_border  = at_border_r;
  assign out_res.frame_last = frame_last_r;

endmodule
